// File: rtl/core/ilid_pkg.sv
// Shared types and codes for the indexed byte list.
// Depends on nothing; imported by ilid_seq, ilid_out and the top module.
package ilid_pkg;

  localparam int POS_W = 10;
  localparam int VAL_W = 8;
  localparam int LEN_W = 11;
  localparam int KIND_W = 2;
  localparam int STAT_W = 2;

  typedef enum logic [KIND_W-1:0] {
    KIND_INSERT = 2'd0,
    KIND_DELETE = 2'd1,
    KIND_READ   = 2'd2
  } kind_t;

  typedef enum logic [STAT_W-1:0] {
    ST_OK       = 2'd0,
    ST_OVERFLOW = 2'd1,
    ST_RANGE    = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SHIFT,
    S_FINISH,
    S_PUT,
    S_RDCAP,
    S_RESP
  } seq_state_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [POS_W-1:0]  position;
    logic [VAL_W-1:0]  value;
  } cmd_t;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [VAL_W-1:0]  read_value;
    logic [LEN_W-1:0]  length;
  } rsp_t;

endpackage

// File: rtl/core/ilid_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module ilid_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/ilid_seq.sv
// Operation sequencer: entry count, range checks and the shift walk over the list RAM.
// Depends on ilid_pkg; drives an ilid_ram and hands one result beat to ilid_out.
module ilid_seq
  import ilid_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cmd_valid,
  output logic                        cmd_ready,
  input  cmd_t                        cmd,
  output logic                        res_valid,
  input  logic                        res_ready,
  output rsp_t                        res,
  output logic                        mem_we,
  output logic [$clog2(CAPACITY)-1:0] mem_waddr,
  output logic [VAL_W-1:0]            mem_wdata,
  output logic                        mem_re,
  output logic [$clog2(CAPACITY)-1:0] mem_raddr,
  input  logic [VAL_W-1:0]            mem_rdata
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  seq_state_t state, state_next;

  logic [CNT_W-1:0]  count;
  logic [AW-1:0]     pos_q;
  logic [VAL_W-1:0]  val_q;
  logic [STAT_W-1:0] status_q;
  logic [VAL_W-1:0]  rd_val;
  logic [AW-1:0]     ptr;
  logic [AW-1:0]     end_ptr;
  logic              up;
  logic              wr_pend;
  logic [AW-1:0]     wr_addr;

  logic [CMP_W-1:0]  pos_c;
  logic [CMP_W-1:0]  cnt_c;
  logic              full;
  logic              ok_ins;
  logic              ok_del;
  logic              ok_rd;
  logic [STAT_W-1:0] st_new;
  logic              take;

  assign pos_c = CMP_W'(cmd.position);
  assign cnt_c = CMP_W'(count);
  assign full  = (count == CNT_W'(CAPACITY));
  assign take  = (state == S_IDLE) && cmd_valid;

  always_comb begin
    ok_ins = 1'b0;
    ok_del = 1'b0;
    ok_rd  = 1'b0;
    st_new = ST_OK;
    case (cmd.kind)
      KIND_INSERT: begin
        if (full) begin
          st_new = ST_OVERFLOW;
        end else if (pos_c > cnt_c) begin
          st_new = ST_RANGE;
        end else begin
          ok_ins = 1'b1;
        end
      end
      KIND_DELETE: begin
        if (pos_c >= cnt_c) begin
          st_new = ST_RANGE;
        end else begin
          ok_del = 1'b1;
        end
      end
      KIND_READ: begin
        if (pos_c >= cnt_c) begin
          st_new = ST_RANGE;
        end else begin
          ok_rd = 1'b1;
        end
      end
      default: st_new = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd_ready  = 1'b0;
    res_valid  = 1'b0;
    case (state)
      S_IDLE: begin
        cmd_ready = 1'b1;
        if (cmd_valid) begin
          if (ok_ins) begin
            state_next = (pos_c == cnt_c) ? S_PUT : S_SHIFT;
          end else if (ok_del) begin
            state_next = ((pos_c + CMP_W'(1)) == cnt_c) ? S_RESP : S_SHIFT;
          end else if (ok_rd) begin
            state_next = S_RDCAP;
          end else begin
            state_next = S_RESP;
          end
        end
      end
      S_SHIFT: begin
        if (ptr == end_ptr) begin
          state_next = S_FINISH;
        end
      end
      S_FINISH: state_next = up ? S_PUT : S_RESP;
      S_PUT:    state_next = S_RESP;
      S_RDCAP:  state_next = S_RESP;
      S_RESP: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      wr_pend <= 1'b0;
    end else begin
      wr_pend <= (state == S_SHIFT);
      if (take && ok_ins) begin
        count <= count + CNT_W'(1);
      end else if (take && ok_del) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  // Insert walks down from the old tail, delete walks up from pos+1.
  // Each read is written one slot away in the next cycle, never on an address still to be read.
  always_ff @(posedge clk) begin
    if (take) begin
      val_q    <= cmd.value;
      pos_q    <= AW'(pos_c);
      status_q <= st_new;
      rd_val   <= '0;
      up       <= ok_ins;
      if (ok_ins) begin
        ptr     <= AW'(count - CNT_W'(1));
        end_ptr <= AW'(pos_c);
      end else begin
        ptr     <= AW'(pos_c + CMP_W'(1));
        end_ptr <= AW'(count - CNT_W'(1));
      end
    end
    if (state == S_SHIFT) begin
      ptr     <= up ? (ptr - AW'(1)) : (ptr + AW'(1));
      wr_addr <= up ? (ptr + AW'(1)) : (ptr - AW'(1));
    end
    if (state == S_RDCAP) begin
      rd_val <= mem_rdata;
    end
  end

  always_comb begin
    mem_we    = wr_pend || (state == S_PUT);
    mem_waddr = wr_pend ? wr_addr : pos_q;
    mem_wdata = wr_pend ? mem_rdata : val_q;
    mem_re    = (state == S_SHIFT) || (take && ok_rd);
    mem_raddr = (state == S_SHIFT) ? ptr : AW'(pos_c);
  end

  assign res.status     = status_q;
  assign res.read_value = rd_val;
  assign res.length     = LEN_W'(count);

endmodule

// File: rtl/core/ilid_out.sv
// Output register stage for result beats; lets the sequencer finish while the sink stalls.
// Depends on ilid_pkg.
module ilid_out
  import ilid_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic res_valid,
  output logic res_ready,
  input  rsp_t res,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  assign res_ready = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_ready) begin
      rsp_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      rsp <= res;
    end
  end

endmodule

// File: rtl/core/indexed_list_insert_delete_top.sv
// Indexed byte list: insert, delete and read by position, one result beat per command beat.
// Depends on ilid_pkg, ilid_ram, ilid_seq and ilid_out.
//
// The list lives in one CAPACITY x 8 RAM with a registered read; the entry count is a
// register. Commands are taken one at a time. An insert at position p on a list of n
// entries moves n-p entries one slot up through the single RAM port pair, one entry per
// cycle; an append moves nothing, and neither does a delete of the tail entry. Results
// sit in an output register, so a stalled sink holds only the next command's result,
// not its acceptance.
// The RAM needs no clearing after reset: only entries below the count are ever read.
module indexed_list_insert_delete_top
  import ilid_pkg::*;
#(
  parameter int CAPACITY = 1024
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_ready,
  input  cmd_t cmd,
  output logic rsp_valid,
  input  logic rsp_ready,
  output rsp_t rsp
);

  localparam int AW = $clog2(CAPACITY);

  logic              res_valid;
  logic              res_ready;
  rsp_t              res;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [VAL_W-1:0]  mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [VAL_W-1:0]  mem_rdata;

  ilid_ram #(
    .WIDTH (VAL_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  ilid_seq #(
    .CAPACITY (CAPACITY)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  ilid_out u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

endmodule
